// File: design/wsfp_pkg.sv
// Package for the wheel speed frame parser: frame constants, status and
// register codes, and the structs passed between the parser's modules.
// No dependencies.
package wsfp_pkg;

  // Frame layout
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] FRAME_BYTES = 4'd9;
  localparam logic [POS_W-1:0] CHECK_POS   = 4'd7;

  // Byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HEADER  = 4'd0;
  localparam logic [POS_W-1:0] POS_ADDR    = 4'd1;
  localparam logic [POS_W-1:0] POS_LEN     = 4'd2;
  localparam logic [POS_W-1:0] POS_LEFT_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_LEFT_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_RIGHT_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_RIGHT_LO = 4'd6;
  localparam logic [POS_W-1:0] POS_CHECK   = 4'd7;
  localparam logic [POS_W-1:0] POS_TAIL    = 4'd8;

  // Register reset values
  localparam logic [7:0] HEADER_RST = 8'hBB;
  localparam logic [7:0] TAIL_RST   = 8'h66;
  localparam logic [7:0] ADDR_RST   = 8'h01;
  localparam logic [7:0] LEN_RST    = 8'h04;

  // APB address width: four 32-bit registers at 4*i
  localparam int unsigned APB_AW = 4;

  // Reported frame status
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HDR_TAIL = 3'd2,
    ST_ADDR     = 3'd3,
    ST_LEN      = 3'd4,
    ST_SUM      = 3'd5
  } status_e;

  // Register indexes
  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_TAIL   = 2'd1,
    REG_ADDR   = 2'd2,
    REG_LEN    = 2'd3
  } reg_idx_e;

  // Expected frame bytes, from the register block
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [7:0] device_address;
    logic [7:0] length_code;
  } cfg_t;

  // One received byte with its chunk marks
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_first;
    logic       chunk_last;
  } byte_t;

  // Input register contents seen by the frame checker
  typedef struct packed {
    logic  valid;
    byte_t data;
  } stage_t;

endpackage

// File: design/wsfp_byte_if.sv
// Byte channel into the wheel speed frame parser (valid/ready).
// No dependencies.
interface wsfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_first;
  logic       chunk_last;

  modport source (output valid, rx_byte, chunk_first, chunk_last, input ready);
  modport sink   (input valid, rx_byte, chunk_first, chunk_last, output ready);
endinterface

// File: design/wsfp_result_if.sv
// Result channel out of the wheel speed frame parser (valid/ready).
// No dependencies.
interface wsfp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] left_wheel;
  logic signed [15:0] right_wheel;

  modport source (output valid, status, left_wheel, right_wheel, input ready);
  modport sink   (input valid, status, left_wheel, right_wheel, output ready);
endinterface

// File: design/wsfp_cfg_regs.sv
// APB register block for the expected header, tail, address and length bytes.
// Depends on wsfp_pkg.
module wsfp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsfp_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output wsfp_pkg::cfg_t               cfg_o
);
  import wsfp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER: cfg_d.header_byte    = pwdata[7:0];
        REG_TAIL:   cfg_d.tail_byte      = pwdata[7:0];
        REG_ADDR:   cfg_d.device_address = pwdata[7:0];
        REG_LEN:    cfg_d.length_code    = pwdata[7:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte    <= HEADER_RST;
      cfg_q.tail_byte      <= TAIL_RST;
      cfg_q.device_address <= ADDR_RST;
      cfg_q.length_code    <= LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      REG_HEADER: prdata = {24'd0, cfg_q.header_byte};
      REG_TAIL:   prdata = {24'd0, cfg_q.tail_byte};
      REG_ADDR:   prdata = {24'd0, cfg_q.device_address};
      REG_LEN:    prdata = {24'd0, cfg_q.length_code};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/wsfp_in_stage.sv
// Input register of the parser: captures one byte per cycle unless stalled and
// holds it until the frame checker advances. Depends on wsfp_pkg, wsfp_byte_if.
module wsfp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  wsfp_byte_if.sink           rx_i,
  input  logic                advance_i,
  output wsfp_pkg::stage_t    stage_o
);
  import wsfp_pkg::*;

  logic  valid_q, valid_d;
  byte_t data_q;
  logic  take;

  // Free when empty or when the held byte moves on this cycle
  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q.rx_byte     <= rx_i.rx_byte;
      data_q.chunk_first <= rx_i.chunk_first;
      data_q.chunk_last  <= rx_i.chunk_last;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

// File: design/wsfp_frame_check.sv
// Frame checker: position counter, running XOR, error flags and speed
// capture, plus the result register. Depends on wsfp_pkg, wsfp_result_if.
module wsfp_frame_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsfp_pkg::cfg_t      cfg_i,
  input  wsfp_pkg::stage_t    stage_i,
  output logic                advance_o,
  wsfp_result_if.source       res_o
);
  import wsfp_pkg::*;

  // Frame state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       xor_q, xor_d;
  logic             hdr_q, hdr_d;
  logic             addr_q, addr_d;
  logic             len_q, len_d;
  logic             sum_q, sum_d;
  logic [15:0]      left_q, left_d;
  logic [15:0]      right_q, right_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  status_e          out_status_q;
  logic [15:0]      out_left_q, out_right_q;

  // Working values for the byte in the input register
  logic [POS_W-1:0] pos_c, pos_n;
  logic [7:0]       xor_c, xor_n;
  logic             hdr_c, hdr_n, addr_c, addr_n, len_c, len_n, sum_c, sum_n;
  logic [15:0]      left_c, left_n, right_c, right_n;
  logic [7:0]       b;
  logic             active, has_res;
  status_e          res_status;

  assign b = stage_i.data.rx_byte;

  // Hold when a result is pending and the receiver stalls
  assign advance_o = stage_i.valid && (!out_valid_q || res_o.ready);

  // A first mark drops any unfinished frame
  always_comb begin
    if (stage_i.data.chunk_first) begin
      pos_c = '0; xor_c = '0; hdr_c = 1'b0; addr_c = 1'b0;
      len_c = 1'b0; sum_c = 1'b0; left_c = '0; right_c = '0;
    end else begin
      pos_c = pos_q; xor_c = xor_q; hdr_c = hdr_q; addr_c = addr_q;
      len_c = len_q; sum_c = sum_q; left_c = left_q; right_c = right_q;
    end
  end

  // Per-byte update
  always_comb begin
    active  = (pos_c < FRAME_BYTES);
    pos_n   = pos_c;
    xor_n   = xor_c;
    hdr_n   = hdr_c;
    addr_n  = addr_c;
    len_n   = len_c;
    sum_n   = sum_c;
    left_n  = left_c;
    right_n = right_c;
    if (active) begin
      pos_n = pos_c + 4'd1;
      if (pos_c < CHECK_POS) begin
        xor_n = xor_c ^ b;
      end
      case (pos_c)
        POS_HEADER:   hdr_n   = (b != cfg_i.header_byte);
        POS_ADDR:     addr_n  = (b != cfg_i.device_address);
        POS_LEN:      len_n   = (b != cfg_i.length_code);
        POS_LEFT_HI:  left_n  = {b, 8'd0};
        POS_LEFT_LO:  left_n  = {left_c[15:8], b};
        POS_RIGHT_HI: right_n = {b, 8'd0};
        POS_RIGHT_LO: right_n = {right_c[15:8], b};
        POS_CHECK:    sum_n   = (b != xor_c);
        default:      hdr_n   = hdr_c || (b != cfg_i.tail_byte);
      endcase
    end
  end

  // Result decision, error priority header/tail, address, length, checksum
  always_comb begin
    has_res    = 1'b0;
    res_status = ST_OK;
    if (active && (pos_n == FRAME_BYTES)) begin
      has_res = 1'b1;
      if (hdr_n)       res_status = ST_HDR_TAIL;
      else if (addr_n) res_status = ST_ADDR;
      else if (len_n)  res_status = ST_LEN;
      else if (sum_n)  res_status = ST_SUM;
      else             res_status = ST_OK;
    end else if (active && stage_i.data.chunk_last) begin
      has_res    = 1'b1;
      res_status = ST_SHORT;
    end
  end

  // Next frame state; a last mark clears it after the byte
  always_comb begin
    pos_d = pos_q; xor_d = xor_q; hdr_d = hdr_q; addr_d = addr_q;
    len_d = len_q; sum_d = sum_q; left_d = left_q; right_d = right_q;
    if (advance_o) begin
      if (stage_i.data.chunk_last) begin
        pos_d = '0; xor_d = '0; hdr_d = 1'b0; addr_d = 1'b0;
        len_d = 1'b0; sum_d = 1'b0; left_d = '0; right_d = '0;
      end else begin
        pos_d = pos_n; xor_d = xor_n; hdr_d = hdr_n; addr_d = addr_n;
        len_d = len_n; sum_d = sum_n; left_d = left_n; right_d = right_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      xor_q   <= '0;
      hdr_q   <= 1'b0;
      addr_q  <= 1'b0;
      len_q   <= 1'b0;
      sum_q   <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      hdr_q   <= hdr_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = has_res;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; speeds only for a good frame
  always_ff @(posedge clk_i) begin
    if (advance_o && has_res) begin
      out_status_q <= res_status;
      out_left_q   <= (res_status == ST_OK) ? left_n  : 16'd0;
      out_right_q  <= (res_status == ST_OK) ? right_n : 16'd0;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.left_wheel  = out_left_q;
  assign res_o.right_wheel = out_right_q;

endmodule

// File: design/wheel_speed_frame_parser.sv
// Wheel speed frame parser top level: APB registers, input register and
// frame checker. Depends on wsfp_pkg, wsfp_byte_if, wsfp_result_if.
// Usage:
//   rx_i carries received bytes, one transaction per byte, with marks for
//   the first and last byte of a chunk. Each chunk is checked as a 9-byte
//   frame (header, address, length code, two big-endian signed speeds,
//   XOR checksum over bytes 0..6, tail). res_o carries one transaction per
//   finished frame or per chunk that ends early (too-short status); bytes
//   past the ninth give no transaction. The APB port holds the expected
//   header, tail, address and length bytes; write it only while no frame
//   is in flight.
// Timing:
//   One byte per cycle sustained while results are taken. A byte accepted
//   into the input register is checked by the combinational checker, and
//   its result is loaded into the result register when the checker advances;
//   the combinational checker between the two registers sets the rate.
// Reset: clears the frame state and both valid bits; the APB registers
//   return to 0xBB, 0x66, 0x01, 0x04.
// Stall: while a result waits and res_o.ready is low, one more byte is held
//   in the input register; then rx_i.ready drops until the result is taken.
module wheel_speed_frame_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsfp_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  wsfp_byte_if.sink                    rx_i,
  wsfp_result_if.source                res_o
);
  import wsfp_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  wsfp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wsfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  wsfp_frame_check u_frame_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .stage_i   (stage),
    .advance_o (advance),
    .res_o     (res_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for wheel_speed_frame_parser: byte stream in, frame reports out,
// registers over APB. Depends on wsfp_pkg, wsfp_byte_if, wsfp_result_if and the parser.
module tb_top;
  import wsfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One decoded frame report as the parser should deliver it
  typedef struct packed {
    status_e     status;
    logic [15:0] left_spd;
    logic [15:0] right_spd;
  } frame_report_t;

  // Bytes of one chunk: a full frame plus room for trailing bytes
  typedef logic [7:0] chunk_t [12];

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  wsfp_byte_if   rx_if ();
  wsfp_result_if res_if ();

  wheel_speed_frame_parser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx_i    (rx_if),
    .res_o   (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shared bench state
  frame_report_t frame_reports_q [$];
  int err_cnt = 0;
  int items_sent = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_len = 0;
  int hold_req_seq = 0;

  // Predictor copy of the registers and the frame state
  cfg_t        cfg_model;
  logic [3:0]  pos_q;
  logic [7:0]  xor_q;
  bit          hdr_bad, addr_bad, len_bad, sum_bad;
  logic [15:0] left_q, right_q;

  function automatic void clear_frame_state();
    pos_q    = '0;
    xor_q    = '0;
    hdr_bad  = 1'b0;
    addr_bad = 1'b0;
    len_bad  = 1'b0;
    sum_bad  = 1'b0;
    left_q   = '0;
    right_q  = '0;
  endfunction

  // Advance the frame checker by one byte; returns 1 when a report is due
  function automatic bit parse_byte(input logic [7:0] b, input bit f, input bit l,
                                    output frame_report_t rep);
    logic [3:0] p;
    bit got;
    got = 1'b0;
    rep.status    = ST_OK;
    rep.left_spd  = '0;
    rep.right_spd = '0;
    if (f) clear_frame_state();
    if (pos_q < FRAME_BYTES) begin
      p = pos_q;
      if (p < CHECK_POS) xor_q = xor_q ^ b;
      case (p)
        POS_HEADER:   hdr_bad = (b != cfg_model.header_byte);
        POS_ADDR:     addr_bad = (b != cfg_model.device_address);
        POS_LEN:      len_bad = (b != cfg_model.length_code);
        POS_LEFT_HI:  left_q = {b, 8'h00};
        POS_LEFT_LO:  left_q = left_q | {8'h00, b};
        POS_RIGHT_HI: right_q = {b, 8'h00};
        POS_RIGHT_LO: right_q = right_q | {8'h00, b};
        POS_CHECK:    sum_bad = (b != xor_q);
        default:      hdr_bad = hdr_bad || (b != cfg_model.tail_byte);
      endcase
      pos_q = p + 4'd1;
      if (pos_q == FRAME_BYTES) begin
        got = 1'b1;
        if (hdr_bad)       rep.status = ST_HDR_TAIL;
        else if (addr_bad) rep.status = ST_ADDR;
        else if (len_bad)  rep.status = ST_LEN;
        else if (sum_bad)  rep.status = ST_SUM;
        if (rep.status == ST_OK) begin
          rep.left_spd  = left_q;
          rep.right_spd = right_q;
        end
      end else if (l) begin
        got = 1'b1;
        rep.status = ST_SHORT;
      end
    end
    if (l) clear_frame_state();
    return got;
  endfunction

  // Well-formed frame for the current register settings, random trailing bytes
  function automatic void make_frame(input logic [15:0] l, input logic [15:0] r,
                                     output chunk_t c);
    logic [7:0] x;
    c[0] = cfg_model.header_byte;
    c[1] = cfg_model.device_address;
    c[2] = cfg_model.length_code;
    c[3] = l[15:8];
    c[4] = l[7:0];
    c[5] = r[15:8];
    c[6] = r[7:0];
    x = '0;
    for (int i = 0; i < 7; i++) x = x ^ c[i];
    c[7] = x;
    c[8] = cfg_model.tail_byte;
    for (int i = 9; i < 12; i++) c[i] = 8'($urandom);
  endfunction

  // Mostly random speeds, with the signed extremes now and then
  function automatic logic [15:0] pick_speed();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one byte, with random idle cycles ahead, and wait for the transaction
  task automatic send_byte(input logic [7:0] b, input bit f, input bit l);
    frame_report_t rep;
    while ($urandom_range(99) < tx_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid       <= 1'b1;
    rx_if.rx_byte     <= b;
    rx_if.chunk_first <= f;
    rx_if.chunk_last  <= l;
    do @(posedge clk_i); while (!rx_if.ready);
    items_sent++;
    if (parse_byte(b, f, l, rep)) frame_reports_q = {frame_reports_q, rep};
  endtask

  task automatic send_chunk(input chunk_t c, input int n, input bit mark_first,
                            input bit mark_last);
    for (int i = 0; i < n; i++)
      send_byte(c[i], mark_first && i == 0, mark_last && i == n - 1);
  endtask

  // Stop offering and let every pending report drain
  task automatic wait_for_reports();
    rx_if.valid <= 1'b0;
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register
  task automatic apb_write(input reg_idx_e idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_HEADER: cfg_model.header_byte    = v;
      REG_TAIL:   cfg_model.tail_byte      = v;
      REG_ADDR:   cfg_model.device_address = v;
      REG_LEN:    cfg_model.length_code    = v;
      default:    ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[7:0] !== v) begin
      $error("register %s: expected %0d, got %0d", idx.name(), v, prdata[7:0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] h, input logic [7:0] t,
                            input logic [7:0] a, input logic [7:0] n);
    apb_write(REG_HEADER, h);
    apb_write(REG_TAIL, t);
    apb_write(REG_ADDR, a);
    apb_write(REG_LEN, n);
  endtask

  // One random chunk: mostly good frames, the rest broken or noise
  task automatic send_random_chunk();
    chunk_t c;
    int kind;
    int k;
    make_frame(pick_speed(), pick_speed(), c);
    kind = $urandom_range(99);
    if (kind < 45) begin
      send_chunk(c, 9, 1'b1, 1'b1);
    end else if (kind < 60) begin
      k = $urandom_range(8);
      c[k] = c[k] ^ 8'($urandom_range(255, 1));
      send_chunk(c, 9, 1'b1, 1'b1);
    end else if (kind < 68) begin
      send_chunk(c, $urandom_range(8, 1), 1'b1, 1'b1);
    end else if (kind < 76) begin
      send_chunk(c, $urandom_range(12, 10), 1'b1, 1'b1);
    end else if (kind < 82) begin
      send_chunk(c, 9, 1'b0, 1'b1);
    end else if (kind < 90) begin
      send_chunk(c, $urandom_range(8, 1), 1'b1, 1'b0);
    end else if (kind < 94) begin
      send_chunk(c, 9, 1'b1, 1'b0);
    end else begin
      k = $urandom_range(6, 1);
      for (int i = 0; i < k; i++)
        send_byte(8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Every status code but the too-short one under the reset register values, speed extremes included
  task automatic test_status_codes();
    chunk_t c;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    make_frame(16'h7FFF, 16'h8000, c);
    send_chunk(c, 9, 1'b1, 1'b1);
    make_frame(16'h0000, 16'hFFFF, c);
    send_chunk(c, 9, 1'b1, 1'b1);
    c[0] = ~c[0];
    send_chunk(c, 9, 1'b1, 1'b1);
    make_frame(pick_speed(), pick_speed(), c);
    c[8] = c[8] ^ 8'h80;
    send_chunk(c, 9, 1'b1, 1'b1);
    make_frame(pick_speed(), pick_speed(), c);
    c[1] = c[1] ^ 8'h10;
    send_chunk(c, 9, 1'b1, 1'b1);
    make_frame(pick_speed(), pick_speed(), c);
    c[2] = c[2] ^ 8'h02;
    send_chunk(c, 9, 1'b1, 1'b1);
    make_frame(pick_speed(), pick_speed(), c);
    c[7] = c[7] ^ 8'h01;
    send_chunk(c, 9, 1'b1, 1'b1);
    // address and length both wrong: address wins
    make_frame(pick_speed(), pick_speed(), c);
    c[1] = ~c[1];
    c[2] = ~c[2];
    send_chunk(c, 9, 1'b1, 1'b1);
    wait_for_reports();
  endtask

  // Chunk marking corner cases
  task automatic test_chunk_marks();
    chunk_t c;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // single byte chunk, then a four byte chunk: both too short
    send_byte(8'hBB, 1'b1, 1'b1);
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 4, 1'b1, 1'b1);
    // trailing bytes past the ninth, last mark on the final one
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 11, 1'b1, 1'b1);
    // new chunk right after a chunk end, without a first mark
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 9, 1'b0, 1'b1);
    // first mark in the middle drops the unfinished chunk
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 5, 1'b1, 1'b0);
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 9, 1'b1, 1'b1);
    // complete frame with no end mark, then ignored bytes closing the chunk
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 9, 1'b1, 1'b0);
    send_chunk(c, 3, 1'b0, 1'b1);
    wait_for_reports();
  endtask

  // Register extremes, checked against frames built for them
  task automatic test_register_settings();
    chunk_t c;
    set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 9, 1'b1, 1'b1);
    c[8] = 8'h00;
    send_chunk(c, 9, 1'b1, 1'b1);
    wait_for_reports();
    set_config(8'hFF, 8'h00, 8'h00, 8'hFF);
    make_frame(pick_speed(), pick_speed(), c);
    send_chunk(c, 9, 1'b1, 1'b1);
    c[2] = 8'h04;
    send_chunk(c, 9, 1'b1, 1'b1);
    wait_for_reports();
    set_config(HEADER_RST, TAIL_RST, ADDR_RST, LEN_RST);
  endtask

  // Random chunks over four idle patterns, new register values per phase
  task automatic test_random_traffic();
    int tx_pct [4] = '{0, 76, 0, 32};
    int rx_pct [4] = '{0, 0, 76, 32};
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      target = items_sent + 85;
      while (items_sent < target) send_random_chunk();
      wait_for_reports();
    end
  endtask

  // Receiver holds off for a long stretch while frames keep coming
  task automatic test_output_backpressure();
    chunk_t c;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_len = 80;
    hold_req_seq++;
    for (int i = 0; i < 5; i++) begin
      make_frame(pick_speed(), pick_speed(), c);
      send_chunk(c, 9, 1'b1, 1'b1);
    end
    wait_for_reports();
  endtask

  // Result side: accept with random stalls, compare against the oldest report
  initial begin
    frame_report_t want;
    int hold_seen_seq;
    int hold_left;
    hold_seen_seq = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (frame_reports_q.size() == 0) begin
          $error("unexpected report: status %0d", res_if.status);
          err_cnt++;
        end else begin
          want = frame_reports_q.pop_front();
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            err_cnt++;
          end
          if (res_if.left_wheel !== want.left_spd) begin
            $error("left_wheel: expected %0d, got %0d", $signed(want.left_spd),
                   res_if.left_wheel);
            err_cnt++;
          end
          if (res_if.right_wheel !== want.right_spd) begin
            $error("right_wheel: expected %0d, got %0d", $signed(want.right_spd),
                   res_if.right_wheel);
            err_cnt++;
          end
        end
      end
      if (hold_req_seq != hold_seen_seq) begin
        hold_seen_seq = hold_req_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = '0;
    rx_if.chunk_first = 1'b0;
    rx_if.chunk_last  = 1'b0;
    cfg_model.header_byte    = HEADER_RST;
    cfg_model.tail_byte      = TAIL_RST;
    cfg_model.device_address = ADDR_RST;
    cfg_model.length_code    = LEN_RST;
    clear_frame_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_status_codes();
    test_chunk_marks();
    test_register_settings();
    test_random_traffic();
    test_output_backpressure();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && frame_reports_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
